@@ design/atc_pkg.sv @@
package atc_pkg;

   localparam int LINE_NUMBER_BITS = 20;
   localparam int CHAR_BITS = 8;
   localparam int RSP_DATA_BITS = ((CHAR_BITS + LINE_NUMBER_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 8;

   typedef logic [LINE_NUMBER_BITS-1:0] line_type;
   typedef logic [CHAR_BITS-1:0] char_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam line_type LINE_MAX = {LINE_NUMBER_BITS{1'b1}};
   localparam line_type LINE_FIRST = line_type'(1);

   localparam char_type CH_QUOTE = 8'h22;
   localparam char_type CH_BACKSLASH = 8'h5C;
   localparam char_type CH_NEWLINE = 8'h0A;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_TAB = 8'h09;
   localparam char_type CH_CR = 8'h0D;

   localparam char_type COMMENT_CHAR_RESET = 8'h23;
   localparam char_type LABEL_CHAR_RESET = 8'h3A;

   localparam csr_index_type REG_COMMENT_CHAR = csr_index_type'(0);
   localparam csr_index_type REG_LABEL_CHAR = csr_index_type'(1);

   localparam logic [1:0] SKIP_NORMAL = 2'd0;
   localparam logic [1:0] SKIP_COMMENT = 2'd1;
   localparam logic [1:0] SKIP_LABEL = 2'd2;
   localparam logic [1:0] SKIP_LABEL_COMMENT = 2'd3;

   typedef struct packed {
      logic       in_quote;
      logic [1:0] skip_mode;
      logic       line_is_empty;
      char_type   last_kept;
      logic       held_space_valid;
      char_type   held_space;
      line_type   source_line;
      line_type   start_line;
   } state_type;

   localparam state_type STATE_RESET = '{
      in_quote: 1'b0,
      skip_mode: SKIP_NORMAL,
      line_is_empty: 1'b1,
      last_kept: '0,
      held_space_valid: 1'b0,
      held_space: '0,
      source_line: LINE_FIRST,
      start_line: LINE_FIRST
   };

   typedef struct packed {
      char_type out_char;
      logic     line_end;
      line_type line_no;
      logic     last_of_run;
   } result_type;

   function automatic logic is_ws(input char_type c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

@@ design/assembly_text_cleaner.sv @@
// channel  | valid/ready          | payload
// req      | req_tvalid/tready    | tdata: in_byte; tlast: end_of_input
// rsp      | rsp_tvalid/tready    | tdata: out_char, line_no; tuser: line_end;
//          |                      | tlast: last_of_run
// csr      | csr_valid/csr_ready  | csr_index, csr_data
//
// One item per cycle while rsp does not stall; the character step is one
// combinational pass between the input register and a two-entry result buffer.
// An item that yields two results holds the next item in the input register while
// the buffer drains.
// A req item passes the input register and then the result buffer to reach rsp.
// Synchronous reset restores the stream state and both character registers.
// rsp stalls back-pressure req while the buffer cannot take the held input item.
module assembly_text_cleaner (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // in_byte
   input  logic                                 req_tlast,   // end_of_input
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [atc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // out_char, line_no, zero pad
   output logic                                 rsp_tuser,   // line_end
   output logic                                 rsp_tlast,   // last_of_run
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  atc_pkg::csr_index_type               csr_index,
   input  atc_pkg::char_type                    csr_data
);

   logic in_valid_ff;
   logic in_valid_in;
   atc_pkg::char_type in_byte_ff;
   atc_pkg::char_type in_byte_in;
   logic in_eoi_ff;
   logic in_eoi_in;
   atc_pkg::state_type state_ff;
   atc_pkg::state_type state_in;
   atc_pkg::char_type comment_char_ff;
   atc_pkg::char_type comment_char_in;
   atc_pkg::char_type label_char_ff;
   atc_pkg::char_type label_char_in;

   atc_pkg::state_type step_nxt;
   logic [1:0] step_count;
   atc_pkg::result_type step_res0;
   atc_pkg::result_type step_res1;
   atc_pkg::result_type head;
   logic free;
   logic advance;
   logic req_fire;

   atc_step u_step (
      .cur(state_ff),
      .comment_char(comment_char_ff),
      .label_char(label_char_ff),
      .in_byte(in_byte_ff),
      .end_of_input(in_eoi_ff),
      .nxt(step_nxt),
      .res_count(step_count),
      .res0(step_res0),
      .res1(step_res1)
   );

   atc_rsp_buf u_rsp_buf (
      .clock(clock),
      .reset(reset),
      .load(advance),
      .load_count(step_count),
      .load0(step_res0),
      .load1(step_res1),
      .free(free),
      .head_valid(rsp_tvalid),
      .head(head),
      .head_ready(rsp_tready)
   );

   always_comb begin
      advance = in_valid_ff && free;
      req_tready = !in_valid_ff || advance;
      req_fire = req_tvalid && req_tready;
      csr_ready = 1'b1;

      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      in_eoi_in = in_eoi_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in = req_tdata;
         in_eoi_in = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in = advance ? step_nxt : state_ff;

      comment_char_in = comment_char_ff;
      label_char_in = label_char_ff;
      if (csr_valid) begin
         unique case (csr_index)
            atc_pkg::REG_COMMENT_CHAR: comment_char_in = csr_data;
            atc_pkg::REG_LABEL_CHAR:   label_char_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= atc_pkg::STATE_RESET;
         comment_char_ff <= atc_pkg::COMMENT_CHAR_RESET;
         label_char_ff <= atc_pkg::LABEL_CHAR_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
         comment_char_ff <= comment_char_in;
         label_char_ff <= label_char_in;
      end
      in_byte_ff <= in_byte_in;
      in_eoi_ff <= in_eoi_in;
   end

   assign rsp_tdata = atc_pkg::RSP_DATA_BITS'({head.line_no, head.out_char});
   assign rsp_tuser = head.line_end;
   assign rsp_tlast = head.last_of_run;

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !free) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_eoi_ff)))
      else $error("stalled item lost from input register");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted item not held");

   a_line_order: assert property (@(posedge clock) disable iff (reset)
      state_ff.start_line <= state_ff.source_line)
      else $error("cleaned line starts after current source line");

   a_line_end_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (head.out_char == '0 && head.last_of_run))
      else $error("line end carries a character or is not final");
`endif

endmodule

@@ design/atc_step.sv @@
module atc_step (
   input  atc_pkg::state_type  cur,
   input  atc_pkg::char_type   comment_char,
   input  atc_pkg::char_type   label_char,
   input  atc_pkg::char_type   in_byte,
   input  logic                end_of_input,
   output atc_pkg::state_type  nxt,
   output logic [1:0]          res_count,
   output atc_pkg::result_type res0,
   output atc_pkg::result_type res1
);

   logic do_held;
   logic do_char;
   logic do_end;
   logic do_normal;
   logic do_emit;
   logic is_label;
   logic nl;
   logic c_ws;
   logic quote_open;
   atc_pkg::line_type bumped;

   always_comb begin
      nl = (in_byte == atc_pkg::CH_NEWLINE);
      c_ws = atc_pkg::is_ws(in_byte);
      quote_open = (in_byte == atc_pkg::CH_QUOTE) && (cur.last_kept != atc_pkg::CH_BACKSLASH);
      bumped = (cur.source_line == atc_pkg::LINE_MAX) ? cur.source_line :
               atc_pkg::line_type'(cur.source_line + 1'b1);
      nxt = cur;
      do_held = 1'b0;
      do_char = 1'b0;
      do_end = 1'b0;
      do_normal = 1'b0;
      do_emit = 1'b0;
      is_label = 1'b0;

      if (end_of_input) begin
         do_end = (cur.skip_mode != atc_pkg::SKIP_COMMENT) && !cur.line_is_empty;
         nxt = atc_pkg::STATE_RESET;
      end else begin
         unique case (cur.skip_mode)
            atc_pkg::SKIP_COMMENT: begin
               if (nl) begin
                  nxt.source_line = bumped;
                  nxt.skip_mode = atc_pkg::SKIP_NORMAL;
                  if (cur.line_is_empty) begin
                     nxt.start_line = bumped;
                  end
               end
            end
            atc_pkg::SKIP_LABEL_COMMENT: begin
               if (nl) begin
                  nxt.source_line = bumped;
                  nxt.skip_mode = atc_pkg::SKIP_LABEL;
               end
            end
            atc_pkg::SKIP_LABEL: begin
               if (c_ws) begin
                  if (nl) begin
                     nxt.source_line = bumped;
                  end
               end else if (in_byte == comment_char) begin
                  nxt.skip_mode = atc_pkg::SKIP_LABEL_COMMENT;
               end else begin
                  nxt.skip_mode = atc_pkg::SKIP_NORMAL;
                  do_normal = 1'b1;
               end
            end
            default: begin
               do_normal = 1'b1;
            end
         endcase

         if (do_normal) begin
            if (nl) begin
               nxt.source_line = bumped;
               do_end = !cur.line_is_empty;
               nxt.line_is_empty = 1'b1;
               nxt.last_kept = '0;
               nxt.held_space_valid = 1'b0;
               nxt.held_space = '0;
               nxt.start_line = bumped;
            end else if (cur.in_quote) begin
               if (quote_open) begin
                  nxt.in_quote = 1'b0;
               end
               do_emit = 1'b1;
            end else if (quote_open) begin
               nxt.in_quote = 1'b1;
               do_emit = 1'b1;
            end else if (c_ws) begin
               if (!cur.line_is_empty && !atc_pkg::is_ws(cur.last_kept)) begin
                  nxt.held_space = in_byte;
                  nxt.held_space_valid = 1'b1;
                  nxt.last_kept = in_byte;
               end
            end else if (in_byte == comment_char) begin
               do_end = !cur.line_is_empty;
               nxt.line_is_empty = 1'b1;
               nxt.last_kept = '0;
               nxt.held_space_valid = 1'b0;
               nxt.held_space = '0;
               nxt.skip_mode = atc_pkg::SKIP_COMMENT;
            end else if (in_byte == label_char) begin
               do_emit = 1'b1;
               is_label = 1'b1;
            end else begin
               do_emit = 1'b1;
            end
         end

         if (do_emit) begin
            do_held = cur.held_space_valid;
            do_char = 1'b1;
            nxt.held_space_valid = 1'b0;
            nxt.last_kept = in_byte;
            nxt.line_is_empty = 1'b0;
         end
         if (is_label) begin
            nxt.held_space = atc_pkg::CH_SPACE;
            nxt.held_space_valid = 1'b1;
            nxt.last_kept = atc_pkg::CH_SPACE;
            nxt.skip_mode = atc_pkg::SKIP_LABEL;
         end
      end

      res_count = {1'b0, do_held} + {1'b0, do_char} + {1'b0, do_end};

      res0.out_char = do_held ? cur.held_space : (do_char ? in_byte : '0);
      res0.line_end = do_end;
      res0.line_no = cur.start_line;
      res0.last_of_run = !(do_held && do_char);

      res1.out_char = in_byte;
      res1.line_end = 1'b0;
      res1.line_no = cur.start_line;
      res1.last_of_run = 1'b1;
   end

endmodule

@@ design/atc_rsp_buf.sv @@
module atc_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [1:0]          load_count,
   input  atc_pkg::result_type load0,
   input  atc_pkg::result_type load1,
   output logic                free,
   output logic                head_valid,
   output atc_pkg::result_type head,
   input  logic                head_ready
);

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   atc_pkg::result_type slot0_ff;
   atc_pkg::result_type slot0_in;
   atc_pkg::result_type slot1_ff;
   atc_pkg::result_type slot1_in;
   logic pop;

   always_comb begin
      pop = (cnt_ff != 2'd0) && head_ready;
      free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && head_ready);
      cnt_in = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in = load_count;
         slot0_in = load0;
         slot1_in = load1;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head_valid = (cnt_ff != 2'd0);
   assign head = slot0_ff;

endmodule
